// ===== hdl/ogru_pkg.sv =====
// ----------------------------------------------------------------------------
// ogru_pkg: shared types and constants of the occupancy grid ray update
// Action codes, cell levels, configuration indexes and the command record
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package ogru_pkg;

    // action codes
    localparam logic [1:0] ACT_MARK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;

    typedef logic        [2:0]  t_level;
    typedef logic signed [8:0]  t_coord;
    typedef logic        [9:0]  t_dist;
    typedef logic signed [11:0] t_err;
    typedef logic        [7:0]  t_dim;

    localparam t_level LEVEL_MID = 3'd3;
    localparam t_level LEVEL_MAX = 3'd6;

    // command queue between front and back
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = 1;
    localparam int CMD_CNT_W = 2;

    // classified command
    typedef struct packed {
        logic [1:0] action;
        t_coord     start_row;
        t_coord     start_col;
        t_coord     end_row;
        t_coord     end_col;
        t_dist      dist_row;
        t_dist      dist_col;
        logic       row_dec;
        logic       col_dec;
        t_err       err_init;
    } t_cmd;

    // effective map size after clamping the configuration
    typedef struct packed {
        t_dim rows;
        t_dim cols;
    } t_dims;

endpackage

// ===== hdl/ogru_ram.sv =====
// ----------------------------------------------------------------------------
// ogru_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ogru_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/ogru_fifo.sv =====
// ----------------------------------------------------------------------------
// ogru_fifo: short command queue
// Decouples the classifying front end from the cell-walking back end.
// ----------------------------------------------------------------------------
module ogru_fifo
    import ogru_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_pop_cmd,
    output logic o_empty
);

    t_cmd                 r_slot [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMD_CNT_W-1:0] r_count, n_count;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    assign o_pop_cmd = r_slot[r_rd_ptr];
    assign o_full    = (r_count == CMD_CNT_W'(CMD_DEPTH));
    assign o_empty   = (r_count == '0);

endmodule

// ===== hdl/ogru_front.sv =====
// ----------------------------------------------------------------------------
// ogru_front: input handshake and command classification
// Works out the line deltas, step directions and initial error term of a
// ray and pushes the classified command into the queue.
// ----------------------------------------------------------------------------
module ogru_front
    import ogru_pkg::*;
(
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  t_coord     i_start_row,
    input  t_coord     i_start_col,
    input  t_coord     i_end_row,
    input  t_coord     i_end_col,
    input  logic       i_init_busy,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_push_cmd
);

    logic signed [9:0] w_diff_row;
    logic signed [9:0] w_diff_col;
    t_dist             w_dist_row;
    t_dist             w_dist_col;

    // absolute deltas
    always_comb begin
        w_diff_row = $signed({i_end_row[8], i_end_row}) - $signed({i_start_row[8], i_start_row});
        w_diff_col = $signed({i_end_col[8], i_end_col}) - $signed({i_start_col[8], i_start_col});
        w_dist_row = w_diff_row[9] ? t_dist'(-w_diff_row) : t_dist'(w_diff_row);
        w_dist_col = w_diff_col[9] ? t_dist'(-w_diff_col) : t_dist'(w_diff_col);
    end

    // classified command
    always_comb begin
        o_push_cmd.action    = i_action;
        o_push_cmd.start_row = i_start_row;
        o_push_cmd.start_col = i_start_col;
        o_push_cmd.end_row   = i_end_row;
        o_push_cmd.end_col   = i_end_col;
        o_push_cmd.dist_row  = w_dist_row;
        o_push_cmd.dist_col  = w_dist_col;
        o_push_cmd.row_dec   = (i_start_row >= i_end_row);
        o_push_cmd.col_dec   = (i_start_col >= i_end_col);
        o_push_cmd.err_init  = $signed({2'b00, w_dist_row}) - $signed({2'b00, w_dist_col});
    end

    // no command taken while the store is being initialised
    assign o_in_ready = !i_full && !i_init_busy;
    assign o_push     = i_in_valid && o_in_ready;

endmodule

// ===== hdl/ogru_back.sv =====
// ----------------------------------------------------------------------------
// ogru_back: cell store and ray walker
// Sequences reads, read-modify-write ray walks and clear sweeps over the
// cell store, and holds the result register.
// ----------------------------------------------------------------------------
module ogru_back
    import ogru_pkg::*;
#(
    parameter int MAP_ROWS = 128,
    parameter int MAP_COLS = 128
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_dims  i_dims,
    input  logic   i_empty,
    input  t_cmd   i_cmd,
    output logic   o_pop,
    output logic   o_init_busy,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_level o_cell_level,
    output logic   o_cell_in_map
);

    localparam int ROW_W  = $clog2(MAP_ROWS);
    localparam int COL_W  = $clog2(MAP_COLS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = 1 << ADDR_W;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    // which cell of the action is being visited
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_MID   = 2'd1;
    localparam logic [1:0] PH_END   = 2'd2;
    localparam logic [1:0] PH_READ  = 2'd3;

    logic [2:0]        r_state, n_state;
    logic              r_init, n_init;
    logic [ADDR_W-1:0] r_sweep, n_sweep;
    t_cmd              r_cmd, n_cmd;
    t_coord            r_row, n_row;
    t_coord            r_col, n_col;
    t_err              r_err, n_err;
    logic [1:0]        r_phase, n_phase;
    logic [ADDR_W-1:0] r_addr, n_addr;
    t_level            r_res_level, n_res_level;
    logic              r_res_in_map, n_res_in_map;
    logic              r_out_valid, n_out_valid;
    t_level            r_out_level, n_out_level;
    logic              r_out_in_map, n_out_in_map;

    logic signed [10:0] w_abs_row;
    logic signed [10:0] w_abs_col;
    logic               w_in_map;
    logic [ADDR_W-1:0]  w_cell_addr;

    logic               w_ram_we;
    logic [ADDR_W-1:0]  w_ram_waddr;
    t_level             w_ram_wdata;
    t_level             w_rd_level;
    t_level             w_new_level;

    logic signed [12:0] w_e2;
    logic signed [12:0] w_dr_ext;
    logic signed [12:0] w_dc_ext;
    logic               w_step_row;
    logic               w_step_col;
    t_coord             w_next_row;
    t_coord             w_next_col;
    t_err               w_next_err;
    logic               w_at_end;
    logic               w_next_at_end;
    t_coord             w_adv_row;
    t_coord             w_adv_col;
    t_err               w_adv_err;
    logic [1:0]         w_adv_phase;
    logic               w_out_load;

    // map position and in-map test of the current cell
    always_comb begin
        w_abs_row = $signed({{2{r_row[8]}}, r_row}) + $signed({4'b0000, i_dims.rows[7:1]});
        w_abs_col = $signed({{2{r_col[8]}}, r_col}) + $signed({4'b0000, i_dims.cols[7:1]});
        w_in_map  = !w_abs_row[10] && (w_abs_row < $signed({3'b000, i_dims.rows}))
                 && !w_abs_col[10] && (w_abs_col < $signed({3'b000, i_dims.cols}));
        w_cell_addr = {w_abs_row[ROW_W-1:0], w_abs_col[COL_W-1:0]};
    end

    // saturating level update for the current phase
    always_comb begin
        case (r_phase)
            PH_START: w_new_level = (w_rd_level >= 3'd2) ? w_rd_level - 3'd2 : 3'd0;
            PH_MID:   w_new_level = (w_rd_level != 3'd0) ? w_rd_level - 3'd1 : 3'd0;
            PH_END:   w_new_level = (w_rd_level >= 3'd4) ? LEVEL_MAX : w_rd_level + 3'd2;
            default:  w_new_level = w_rd_level;
        endcase
    end

    // one Bresenham step from the current cell
    always_comb begin
        w_e2       = $signed({r_err, 1'b0});
        w_dr_ext   = $signed({3'b000, r_cmd.dist_row});
        w_dc_ext   = $signed({3'b000, r_cmd.dist_col});
        w_step_row = (w_e2 > -w_dc_ext);
        w_step_col = (w_e2 < w_dr_ext);
        w_next_err = r_err - (w_step_row ? $signed({2'b00, r_cmd.dist_col}) : 12'sd0)
                           + (w_step_col ? $signed({2'b00, r_cmd.dist_row}) : 12'sd0);
        w_next_row = r_row;
        w_next_col = r_col;
        if (w_step_row) begin
            w_next_row = r_cmd.row_dec ? r_row - 9'sd1 : r_row + 9'sd1;
        end
        if (w_step_col) begin
            w_next_col = r_cmd.col_dec ? r_col - 9'sd1 : r_col + 9'sd1;
        end
        w_at_end      = (r_row == r_cmd.end_row) && (r_col == r_cmd.end_col);
        w_next_at_end = (w_next_row == r_cmd.end_row) && (w_next_col == r_cmd.end_col);
    end

    // move on to the next cell of the ray
    always_comb begin
        if (w_at_end) begin
            w_adv_row   = r_row;
            w_adv_col   = r_col;
            w_adv_err   = r_err;
            w_adv_phase = PH_END;
        end else begin
            w_adv_row   = w_next_row;
            w_adv_col   = w_next_col;
            w_adv_err   = w_next_err;
            w_adv_phase = w_next_at_end ? PH_END : PH_MID;
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_init       = r_init;
        n_sweep      = r_sweep;
        n_cmd        = r_cmd;
        n_row        = r_row;
        n_col        = r_col;
        n_err        = r_err;
        n_phase      = r_phase;
        n_addr       = r_addr;
        n_res_level  = r_res_level;
        n_res_in_map = r_res_in_map;
        o_pop        = 1'b0;
        w_ram_we     = 1'b0;
        w_ram_waddr  = r_addr;
        w_ram_wdata  = w_new_level;
        w_out_load   = 1'b0;

        case (r_state)
            // sweep the whole store back to the middle level
            S_CLR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_sweep;
                w_ram_wdata = LEVEL_MID;
                n_sweep     = r_sweep + 1'b1;
                if (&r_sweep) begin
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_res_level  = 3'd0;
                        n_res_in_map = 1'b0;
                        n_state      = S_OUT;
                    end
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop        = 1'b1;
                    n_cmd        = i_cmd;
                    n_res_level  = 3'd0;
                    n_res_in_map = 1'b0;
                    case (i_cmd.action)
                        ACT_MARK: begin
                            n_row   = i_cmd.start_row;
                            n_col   = i_cmd.start_col;
                            n_err   = i_cmd.err_init;
                            n_phase = PH_START;
                            n_state = S_RD;
                        end
                        ACT_READ: begin
                            n_row   = i_cmd.end_row;
                            n_col   = i_cmd.end_col;
                            n_phase = PH_READ;
                            n_state = S_RD;
                        end
                        ACT_CLEAR: begin
                            n_sweep = '0;
                            n_state = S_CLR;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            // issue the read, or skip a cell outside the map
            S_RD: begin
                if (w_in_map) begin
                    n_addr  = w_cell_addr;
                    n_state = S_MOD;
                end else if (r_phase == PH_END || r_phase == PH_READ) begin
                    n_res_level  = 3'd0;
                    n_res_in_map = 1'b0;
                    n_state      = S_OUT;
                end else begin
                    n_row   = w_adv_row;
                    n_col   = w_adv_col;
                    n_err   = w_adv_err;
                    n_phase = w_adv_phase;
                end
            end
            // read data back: update the cell and move on
            S_MOD: begin
                w_ram_we = (r_phase != PH_READ);
                if (r_phase == PH_END || r_phase == PH_READ) begin
                    n_res_level  = w_new_level;
                    n_res_in_map = 1'b1;
                    n_state      = S_OUT;
                end else begin
                    n_row   = w_adv_row;
                    n_col   = w_adv_col;
                    n_err   = w_adv_err;
                    n_phase = w_adv_phase;
                    n_state = S_RD;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result register
    always_comb begin
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_level  = r_out_level;
        n_out_in_map = r_out_in_map;
        if (w_out_load) begin
            n_out_valid  = 1'b1;
            n_out_level  = r_res_level;
            n_out_in_map = r_res_in_map;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_init      <= 1'b1;
            r_sweep     <= '0;
            r_phase     <= PH_START;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_sweep     <= n_sweep;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_row        <= n_row;
        r_col        <= n_col;
        r_err        <= n_err;
        r_addr       <= n_addr;
        r_res_level  <= n_res_level;
        r_res_in_map <= n_res_in_map;
        r_out_level  <= n_out_level;
        r_out_in_map <= n_out_in_map;
    end

    // cell store
    ogru_ram #(
        .WIDTH ($bits(t_level)),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_ram_waddr),
        .i_wr_data (w_ram_wdata),
        .i_rd_addr (w_cell_addr),
        .o_rd_data (w_rd_level)
    );

    assign o_init_busy   = r_init;
    assign o_out_valid   = r_out_valid;
    assign o_cell_level  = r_out_level;
    assign o_cell_in_map = r_out_in_map;

endmodule

// ===== hdl/occupancy_grid_ray_update.sv =====
// Mark ray: each cell on the map is visited in S_RD (read issued) and then S_MOD (level
//   written back); cells off the map are only stepped over in S_RD.
// Read: one cell is read and reported. Clear: every cell of the store is rewritten.
// Items are processed one at a time; a two-entry queue holds further commands.
// After reset the store is swept to the middle level while no command is taken.
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update: occupancy grid ray update, top level
// Configuration registers, front-end classifier, command queue and the
// cell-walking back end with its store.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_update
    import ogru_pkg::*;
#(
    parameter int MAP_ROWS = 128,
    parameter int MAP_COLS = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  t_coord     i_start_row,
    input  t_coord     i_start_col,
    input  t_coord     i_end_row,
    input  t_coord     i_end_col,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_level     o_cell_level,
    output logic       o_cell_in_map
);

    t_dim  r_rows_in_use;
    t_dim  r_cols_in_use;
    t_dims w_dims;
    logic  w_init_busy;
    logic  w_full;
    logic  w_empty;
    logic  w_push;
    logic  w_pop;
    t_cmd  w_push_cmd;
    t_cmd  w_pop_cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= 8'd128;
            r_cols_in_use <= 8'd128;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_ROWS) begin
                r_rows_in_use <= i_cfg_data;
            end else if (i_cfg_index == CFG_COLS) begin
                r_cols_in_use <= i_cfg_data;
            end
        end
    end

    // clamp to 1 .. map size
    always_comb begin
        if (r_rows_in_use == 8'd0) begin
            w_dims.rows = 8'd1;
        end else if (32'(r_rows_in_use) > MAP_ROWS) begin
            w_dims.rows = 8'(MAP_ROWS);
        end else begin
            w_dims.rows = r_rows_in_use;
        end
        if (r_cols_in_use == 8'd0) begin
            w_dims.cols = 8'd1;
        end else if (32'(r_cols_in_use) > MAP_COLS) begin
            w_dims.cols = 8'(MAP_COLS);
        end else begin
            w_dims.cols = r_cols_in_use;
        end
    end

    ogru_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_start_row (i_start_row),
        .i_start_col (i_start_col),
        .i_end_row   (i_end_row),
        .i_end_col   (i_end_col),
        .i_init_busy (w_init_busy),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_cmd  (w_push_cmd)
    );

    ogru_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_pop_cmd  (w_pop_cmd),
        .o_empty    (w_empty)
    );

    ogru_back #(
        .MAP_ROWS (MAP_ROWS),
        .MAP_COLS (MAP_COLS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dims        (w_dims),
        .i_empty       (w_empty),
        .i_cmd         (w_pop_cmd),
        .o_pop         (w_pop),
        .o_init_busy   (w_init_busy),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cell_level  (o_cell_level),
        .o_cell_in_map (o_cell_in_map)
    );

endmodule

// ===== bench/tb_occupancy_grid_ray_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_occupancy_grid_ray_update: self-checking bench for the grid ray update
// Drives ray marks, cell reads, map clears and the unused action code over a
// valid/ready link. A cell-level model of the map predicts every result in
// step with each accepted transaction. Map sizes are swept between phases,
// and traffic runs under three idling patterns plus one long output hold-off.
// ----------------------------------------------------------------------------
module tb_occupancy_grid_ray_update;
    import ogru_pkg::*;

    localparam int MAP_ROWS     = 128;
    localparam int MAP_COLS     = 128;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;

    // action code with no function, and register indexes past the list
    localparam logic [1:0] ACT_NONE     = 2'd3;
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        t_level level;
        logic   in_map;
    } t_cell_report;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic [1:0] i_cfg_index   = CFG_ROWS;
    logic [7:0] i_cfg_data    = '0;
    logic       i_in_valid    = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_action      = ACT_READ;
    t_coord     i_start_row   = '0;
    t_coord     i_start_col   = '0;
    t_coord     i_end_row     = '0;
    t_coord     i_end_col     = '0;
    logic       o_out_valid;
    logic       i_out_ready   = 1'b0;
    t_level     o_cell_level;
    logic       o_cell_in_map;

    // map model and the reports still owed by the block
    t_level       cell_model [MAP_ROWS * MAP_COLS];
    t_dim         rows_reg = 8'd128;
    t_dim         cols_reg = 8'd128;
    t_cell_report expected_cells [$];

    int snd_idle_pct = 7;
    int rcv_idle_pct = 63;
    logic hold_request = 1'b0;
    int hold_left = 0;

    int cycle_count = 0;
    int stall_cycles = 0;
    int fail_count = 0;
    int result_count = 0;
    int ray_count = 0;
    int read_count = 0;
    int clear_count = 0;
    int unused_count = 0;
    int size_settings = 0;

    occupancy_grid_ray_update #(
        .MAP_ROWS (MAP_ROWS),
        .MAP_COLS (MAP_COLS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_start_row   (i_start_row),
        .i_start_col   (i_start_col),
        .i_end_row     (i_end_row),
        .i_end_col     (i_end_col),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cell_level  (o_cell_level),
        .o_cell_in_map (o_cell_in_map)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------------
    // Map model
    // ------------------------------------------------------------------------

    // a size of 0 acts as 1, anything past the store acts as the store size
    function automatic int clamp_dim(t_dim v, int cap);
        if (v == 0) return 1;
        if (int'(v) > cap) return cap;
        return int'(v);
    endfunction

    // store index of a cell given relative to the origin, -1 when off the map
    function automatic int grid_index(int rel_r, int rel_c);
        int nr, nc, r, c;
        nr = clamp_dim(rows_reg, MAP_ROWS);
        nc = clamp_dim(cols_reg, MAP_COLS);
        r  = (nr >> 1) + rel_r;
        c  = (nc >> 1) + rel_c;
        if (r < 0 || r >= nr || c < 0 || c >= nc) return -1;
        return r * MAP_COLS + c;
    endfunction

    function automatic void lower_cell(int rel_r, int rel_c);
        int idx;
        idx = grid_index(rel_r, rel_c);
        if (idx >= 0 && cell_model[idx] > 0) cell_model[idx] = cell_model[idx] - 3'd1;
    endfunction

    function automatic void raise_cell(int rel_r, int rel_c);
        int idx;
        idx = grid_index(rel_r, rel_c);
        if (idx >= 0 && cell_model[idx] < LEVEL_MAX) cell_model[idx] = cell_model[idx] + 3'd1;
    endfunction

    function automatic void clear_map();
        foreach (cell_model[i]) cell_model[i] = LEVEL_MID;
    endfunction

    // Bresenham walk over all octants: start lowered twice, cells between
    // lowered once, end raised twice
    function automatic void walk_ray(int r0, int c0, int r1, int c1);
        int dr, dc, step_r, step_c, err, e2, r, c;
        dr     = (r1 > r0) ? r1 - r0 : r0 - r1;
        dc     = (c1 > c0) ? c1 - c0 : c0 - c1;
        step_r = (r0 < r1) ? 1 : -1;
        step_c = (c0 < c1) ? 1 : -1;
        err    = dr - dc;
        r      = r0;
        c      = c0;
        lower_cell(r, c);
        lower_cell(r, c);
        while (r != r1 || c != c1) begin
            e2 = 2 * err;
            if (e2 > -dc) begin
                err -= dc;
                r   += step_r;
            end
            if (e2 < dr) begin
                err += dr;
                c   += step_c;
            end
            if (r == r1 && c == c1) break;
            lower_cell(r, c);
        end
        raise_cell(r1, c1);
        raise_cell(r1, c1);
    endfunction

    function automatic t_cell_report cell_report(int rel_r, int rel_c);
        t_cell_report rep;
        int idx;
        rep = '0;
        idx = grid_index(rel_r, rel_c);
        if (idx >= 0) begin
            rep.level  = cell_model[idx];
            rep.in_map = 1'b1;
        end
        return rep;
    endfunction

    // applies one command to the model and returns the report it yields
    function automatic t_cell_report apply_command(logic [1:0] act, t_coord sr, t_coord sc,
                                                   t_coord er, t_coord ec);
        t_cell_report rep;
        rep = '0;
        case (act)
            ACT_MARK: begin
                walk_ray(sr, sc, er, ec);
                rep = cell_report(er, ec);
            end
            ACT_READ: rep = cell_report(er, ec);
            ACT_CLEAR: clear_map();
            default: ;
        endcase
        return rep;
    endfunction

    // ------------------------------------------------------------------------
    // Output side: ready pattern, long hold-off, result checking
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_cell_report want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            result_count++;
            if (expected_cells.size() == 0) begin
                $error("result with nothing expected: cell_level %0d cell_in_map %0d",
                       o_cell_level, o_cell_in_map);
                fail_count++;
            end else begin
                want = expected_cells.pop_front();
                if (o_cell_level !== want.level) begin
                    $error("cell_level: expected %0d, actual %0d", want.level, o_cell_level);
                    fail_count++;
                end
                if (o_cell_in_map !== want.in_map) begin
                    $error("cell_in_map: expected %0d, actual %0d", want.in_map,
                           o_cell_in_map);
                    fail_count++;
                end
            end
        end
    end

    // watchdog, plus a count of cycles the input was held back
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_in_valid && o_in_ready !== 1'b1) stall_cycles++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_occupancy_grid_ray_update NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // offers one command and, once accepted, records its expected report
    task automatic send_cmd(input logic [1:0] act, input t_coord sr, input t_coord sc,
                            input t_coord er, input t_coord ec);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_start_row <= sr;
        i_start_col <= sc;
        i_end_row   <= er;
        i_end_col   <= ec;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        expected_cells.push_back(apply_command(act, sr, sc, er, ec));
        case (act)
            ACT_MARK:  ray_count++;
            ACT_READ:  read_count++;
            ACT_CLEAR: clear_count++;
            default:   unused_count++;
        endcase
    endtask

    // stop offering and let every owed report come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (index)
            CFG_ROWS: rows_reg = data;
            CFG_COLS: cols_reg = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_map_size(input t_dim rows, input t_dim cols);
        wait_idle();
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_COLS, cols);
        size_settings++;
    endtask

    // mostly near the origin so cells saturate; sometimes any 9-bit value
    function automatic t_coord pick_coord(int extent);
        int roll, half;
        roll = $urandom_range(99);
        half = extent / 2 + 2;
        if (roll < 8) return t_coord'($urandom_range(511));
        if (roll < 45) return t_coord'(int'($urandom_range(8)) - 4);
        return t_coord'(int'($urandom_range(2 * half)) - half);
    endfunction

    task automatic send_random_cmd();
        int roll, nr, nc;
        logic [1:0] act;
        roll = $urandom_range(999);
        nr   = clamp_dim(rows_reg, MAP_ROWS);
        nc   = clamp_dim(cols_reg, MAP_COLS);
        if (roll < 20)       act = ACT_CLEAR;
        else if (roll < 30)  act = ACT_NONE;
        else if (roll < 330) act = ACT_READ;
        else                 act = ACT_MARK;
        send_cmd(act, pick_coord(nr), pick_coord(nc), pick_coord(nr), pick_coord(nc));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_directed();
        // origin, then a ray that starts and ends on the same cell
        send_cmd(ACT_READ, 9'sd0, 9'sd0, 9'sd0, 9'sd0);
        send_cmd(ACT_MARK, 9'sd0, 9'sd0, 9'sd0, 9'sd0);
        // map corners and just past the edges
        send_cmd(ACT_READ, 9'sd0, 9'sd0, -9'sd64, -9'sd64);
        send_cmd(ACT_READ, 9'sd0, 9'sd0, 9'sd63, 9'sd63);
        send_cmd(ACT_READ, 9'sd0, 9'sd0, 9'sd64, 9'sd0);
        send_cmd(ACT_READ, 9'sd0, 9'sd0, 9'sd0, -9'sd65);
        // shallow, reversed, steep, horizontal and vertical rays
        send_cmd(ACT_MARK, -9'sd5, -9'sd3, 9'sd4, 9'sd7);
        send_cmd(ACT_MARK, 9'sd4, 9'sd7, -9'sd5, -9'sd3);
        send_cmd(ACT_MARK, 9'sd10, 9'sd2, -9'sd6, 9'sd9);
        send_cmd(ACT_MARK, 9'sd0, 9'sd0, 9'sd0, -9'sd12);
        send_cmd(ACT_MARK, 9'sd3, 9'sd3, -9'sd9, 9'sd3);
        // field extremes: both ends off the map, start off the map
        send_cmd(ACT_MARK, -9'sd256, -9'sd256, 9'sd255, 9'sd255);
        send_cmd(ACT_MARK, 9'sd255, -9'sd256, -9'sd256, 9'sd255);
        send_cmd(ACT_MARK, -9'sd256, 9'sd0, 9'sd2, 9'sd2);
        // repeated ray: end saturates high, start saturates low
        repeat (3) send_cmd(ACT_MARK, 9'sd1, 9'sd1, 9'sd8, 9'sd5);
        send_cmd(ACT_READ, 9'sd0, 9'sd0, 9'sd1, 9'sd1);
        // unused action changes nothing
        send_cmd(ACT_NONE, 9'sd255, 9'sd255, 9'sd8, 9'sd5);
        send_cmd(ACT_READ, 9'sd0, 9'sd0, 9'sd8, 9'sd5);
        // clear, then the saturated cell is back at the middle level
        send_cmd(ACT_CLEAR, -9'sd1, -9'sd1, -9'sd1, -9'sd1);
        send_cmd(ACT_READ, 9'sd0, 9'sd0, 9'sd8, 9'sd5);
    endtask

    task automatic test_map_sizes();
        t_dim rows_set [9] = '{8'd0, 8'd1, 8'd255, 8'd128, 8'd1, 8'd128, 8'd2, 8'd127, 8'd200};
        t_dim cols_set [9] = '{8'd0, 8'd1, 8'd255, 8'd128, 8'd128, 8'd1, 8'd3, 8'd5, 8'd64};
        int nr, nc, lo_r, hi_r, lo_c, hi_c;
        for (int k = 0; k < 9; k++) begin
            set_map_size(rows_set[k], cols_set[k]);
            nr   = clamp_dim(rows_reg, MAP_ROWS);
            nc   = clamp_dim(cols_reg, MAP_COLS);
            lo_r = -(nr >> 1);
            hi_r = nr - 1 - (nr >> 1);
            lo_c = -(nc >> 1);
            hi_c = nc - 1 - (nc >> 1);
            send_cmd(ACT_MARK, t_coord'(lo_r), t_coord'(lo_c), t_coord'(hi_r), t_coord'(hi_c));
            send_cmd(ACT_READ, '0, '0, t_coord'(lo_r), t_coord'(lo_c));
            send_cmd(ACT_READ, '0, '0, t_coord'(lo_r), t_coord'(hi_c));
            send_cmd(ACT_READ, '0, '0, t_coord'(hi_r), t_coord'(lo_c));
            send_cmd(ACT_READ, '0, '0, t_coord'(hi_r), t_coord'(hi_c));
            send_cmd(ACT_READ, '0, '0, t_coord'(hi_r + 1), t_coord'(lo_c));
            send_cmd(ACT_READ, '0, '0, t_coord'(lo_r), t_coord'(lo_c - 1));
            repeat (3) send_random_cmd();
        end
        // writes past the register list leave the size alone
        wait_idle();
        write_reg(CFG_SPARE_LO, 8'hFF);
        write_reg(CFG_SPARE_HI, 8'h00);
        send_cmd(ACT_READ, '0, '0, 9'sd0, -9'sd33);
        send_cmd(ACT_READ, '0, '0, 9'sd99, 9'sd31);
    endtask

    task automatic test_random_traffic();
        // sender mostly busy, receiver mostly stalled
        snd_idle_pct = 7;
        rcv_idle_pct = 63;
        set_map_size(8'd128, 8'd128);
        repeat (130) send_random_cmd();
        // the other way round
        snd_idle_pct = 63;
        rcv_idle_pct = 7;
        set_map_size(t_dim'($urandom_range(1, 255)), t_dim'($urandom_range(1, 255)));
        repeat (130) send_random_cmd();
        // full rate both sides
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        set_map_size(t_dim'($urandom_range(255)), t_dim'($urandom_range(255)));
        repeat (130) send_random_cmd();
    endtask

    // long output hold-off while short rays keep coming, to fill the queue
    task automatic test_back_pressure();
        set_map_size(8'd128, 8'd128);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_request = 1'b1;
        for (int k = 0; k < 12; k++)
            send_cmd(ACT_MARK, '0, '0, t_coord'(k - 6), t_coord'(5 - k));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        clear_map();

        test_directed();
        test_map_sizes();
        test_random_traffic();
        test_back_pressure();
        wait_idle();

        $display("Checked %0d results: %0d ray marks, %0d reads, %0d clears, %0d unused.",
                 result_count, ray_count, read_count, clear_count, unused_count);
        $display("%0d map size settings; input held back for %0d cycles in %0d cycles.",
                 size_settings, stall_cycles, cycle_count);
        if (fail_count == 0) begin
            $display("tb_occupancy_grid_ray_update OK");
        end else begin
            $display("tb_occupancy_grid_ray_update NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ogru_pkg.sv
hdl/ogru_ram.sv
hdl/ogru_fifo.sv
hdl/ogru_front.sv
hdl/ogru_back.sv
hdl/occupancy_grid_ray_update.sv
bench/tb_occupancy_grid_ray_update.sv
